// ----- rtl/arwc_pkg.sv -----
// Shared types and constants for the anti-replay window with ceiling unit.
// Holds command and status codes, the register map and the result struct.
// Depends on nothing.
package arwc_pkg;

	localparam int WINDOW_BITS_DEF = 64;
	localparam int CTR_W = 64;
	localparam int RES_W = 32;
	localparam int ADDR_W = 3;
	localparam logic [31:0] RESERVATION_RESET = 32'd1024;

	localparam logic REG_RESERVATION = 1'b0;

	typedef enum logic [1:0] {
		CMD_OPEN_FRESH    = 2'd0,
		CMD_OPEN_RESTORED = 2'd1,
		CMD_ACCEPT        = 2'd2,
		CMD_CLOSE         = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SUCCESS  = 2'd0,
		ST_REPLAYED = 2'd1,
		ST_NOT_OPEN = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             commit_valid;
		logic [CTR_W-1:0] commit_value;
	} result_t;

endpackage

// ----- rtl/arwc_apb.sv -----
// Configuration register file of the anti-replay window with ceiling unit.
// Holds the reservation register behind an APB-style port.
// Depends on arwc_pkg.
module arwc_apb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [arwc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [arwc_pkg::RES_W-1:0]    reservation
);

	logic [arwc_pkg::RES_W-1:0] reservation_q;
	logic                       sel_res;

	assign sel_res = (paddr[arwc_pkg::ADDR_W-1] == arwc_pkg::REG_RESERVATION);
	assign pready = 1'b1;
	assign reservation = reservation_q;
	assign prdata = sel_res ? reservation_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reservation_q <= arwc_pkg::RESERVATION_RESET;
		end else if (psel && penable && pwrite && pready && sel_res) begin
			reservation_q <= pwdata;
		end
	end

endmodule

// ----- rtl/arwc_core.sv -----
// Window state and the single-pass update logic for one command.
// Produces the result of a command and updates the state when stepped.
// Depends on arwc_pkg.
module arwc_core #(
	parameter int WINDOW_BITS = arwc_pkg::WINDOW_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [1:0]                    command,
	input  logic [arwc_pkg::CTR_W-1:0]    counter,
	input  logic [arwc_pkg::RES_W-1:0]    reservation,
	output arwc_pkg::result_t             result
);

	localparam int IW = $clog2(WINDOW_BITS);
	localparam logic [arwc_pkg::CTR_W-1:0] WIN = arwc_pkg::CTR_W'(WINDOW_BITS);

	logic                         open_q, live_q, held_q;
	logic [arwc_pkg::CTR_W-1:0]   high_q, ceil_q;
	logic [WINDOW_BITS-1:0]       mask_q;

	logic                         open_n, live_n, held_n;
	logic [arwc_pkg::CTR_W-1:0]   high_n, ceil_n;
	logic [WINDOW_BITS-1:0]       mask_n;

	logic                         above;
	logic [arwc_pkg::CTR_W-1:0]   d_up, d_dn, top;
	logic                         far_up, far_dn, hit;
	logic [WINDOW_BITS-1:0]       shifted, marked;
	logic [arwc_pkg::CTR_W:0]     sum;
	logic [arwc_pkg::CTR_W-1:0]   reserved;

	assign above = counter > high_q;
	assign d_up = counter - high_q;
	assign d_dn = high_q - counter;
	assign far_up = d_up >= WIN;
	assign far_dn = d_dn >= WIN;
	assign shifted = (mask_q << d_up[IW-1:0]) | WINDOW_BITS'(1);
	assign marked = mask_q | (WINDOW_BITS'(1) << d_dn[IW-1:0]);
	assign hit = mask_q[d_dn[IW-1:0]];
	assign top = (!live_q || above) ? counter : high_q;
	assign sum = {1'b0, top} + {{(arwc_pkg::CTR_W + 1 - arwc_pkg::RES_W){1'b0}}, reservation};
	assign reserved = sum[arwc_pkg::CTR_W] ? {arwc_pkg::CTR_W{1'b1}} :
		sum[arwc_pkg::CTR_W-1:0];

	always_comb begin
		open_n = open_q;
		live_n = live_q;
		held_n = held_q;
		high_n = high_q;
		ceil_n = ceil_q;
		mask_n = mask_q;
		result.status = arwc_pkg::ST_SUCCESS;
		result.commit_valid = 1'b0;
		result.commit_value = '0;
		case (command)
			arwc_pkg::CMD_OPEN_FRESH: begin
				open_n = 1'b1;
				live_n = 1'b0;
				held_n = 1'b0;
				high_n = '0;
				ceil_n = '0;
				mask_n = '0;
			end
			arwc_pkg::CMD_OPEN_RESTORED: begin
				open_n = 1'b1;
				live_n = 1'b1;
				held_n = 1'b1;
				high_n = counter;
				ceil_n = counter;
				mask_n = '1;
			end
			arwc_pkg::CMD_ACCEPT: begin
				if (!open_q) begin
					result.status = arwc_pkg::ST_NOT_OPEN;
				end else if (live_q && !above && (far_dn || hit)) begin
					result.status = arwc_pkg::ST_REPLAYED;
				end else begin
					if (!live_q) begin
						mask_n = WINDOW_BITS'(1);
					end else if (above) begin
						mask_n = far_up ? WINDOW_BITS'(1) : shifted;
					end else begin
						mask_n = marked;
					end
					high_n = top;
					live_n = 1'b1;
					if (!held_q || top > ceil_q) begin
						result.commit_valid = 1'b1;
						result.commit_value = reserved;
						ceil_n = reserved;
						held_n = 1'b1;
					end
				end
			end
			default: begin
				if (open_q && live_q && held_q && high_q < ceil_q) begin
					result.commit_valid = 1'b1;
					result.commit_value = high_q;
				end
				open_n = 1'b0;
				live_n = 1'b0;
				held_n = 1'b0;
				high_n = '0;
				ceil_n = '0;
				mask_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			live_q <= 1'b0;
			held_q <= 1'b0;
			high_q <= '0;
			ceil_q <= '0;
			mask_q <= '0;
		end else if (step) begin
			open_q <= open_n;
			live_q <= live_n;
			held_q <= held_n;
			high_q <= high_n;
			ceil_q <= ceil_n;
			mask_q <= mask_n;
		end
	end

endmodule

// ----- rtl/anti_replay_window_with_ceiling_unit.sv -----
// Top level of the anti-replay window with ceiling unit.
// Instantiates arwc_apb and arwc_core; uses arwc_pkg.
//
// Each request on the input channel (in_valid/in_ready) carries a command and a
// counter. Exactly one result leaves on the output channel (out_valid/out_ready)
// per request, in order: a status and an optional ceiling commit.
// A request is registered in the input register at acceptance, then its window
// update and result are computed combinationally and written to the output
// register, which drives out_valid.
// One request is accepted every cycle while the output is taken. The update of
// the window state in the second stage sets this rate.
// When the receiver stalls, the output register holds its result and one more
// request waits in the input register; in_ready then falls until out_ready.
// Reset clears the window (closed, no ceiling held), empties both stages and
// sets the reservation register to 1024. The user writes configuration via the
// APB-style port only while no request is in flight; the block does not check.
module anti_replay_window_with_ceiling_unit #(
	parameter int WINDOW_BITS = arwc_pkg::WINDOW_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [arwc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [arwc_pkg::CTR_W-1:0]    counter,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic                          commit_valid,
	output logic [arwc_pkg::CTR_W-1:0]    commit_value
);

	logic                         valid_s1, valid_s2;
	logic [1:0]                   command_s1;
	logic [arwc_pkg::CTR_W-1:0]   counter_s1;
	arwc_pkg::result_t            result, result_s2;
	logic [arwc_pkg::RES_W-1:0]   reservation;
	logic                         adv;

	assign adv = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	arwc_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.reservation (reservation)
	);

	arwc_core #(
		.WINDOW_BITS (WINDOW_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (valid_s1 && adv),
		.command     (command_s1),
		.counter     (counter_s1),
		.reservation (reservation),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			counter_s1 <= counter;
		end
		if (adv && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign status = result_s2.status;
	assign commit_valid = result_s2.commit_valid;
	assign commit_value = result_s2.commit_value;

endmodule
